>>> hw/rtl/agenv_pkg.sv
// Shared types and constants for the asymmetric Gaussian envelope block.
// Holds register indexes, field widths and fixed-point constants; no dependencies.
package agenv_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegCenterTime = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRiseCoeff  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFallCoeff  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegEnvMin     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPeakAmp    = 3'd4;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CoefW  = 32;
  localparam int unsigned EnvW   = 16;
  localparam int unsigned DistW  = 24;
  localparam int unsigned ExpW   = 24;
  localparam int unsigned YW     = 25;
  localparam int unsigned ShiftW = 9;

  localparam logic [16:0] Log2eQ16 = 17'd94548;

  typedef logic [EnvW-1:0] env_t;

endpackage

>>> hw/rtl/asymmetric_gaussian_envelope.sv
// Asymmetric Gaussian pulse envelope, top level.
// Nine-stage pipeline with the 2^(-k/N) table built at elaboration; uses agenv_pkg.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one signed time_tick_i per item.
//   Output channel: out_valid_o / out_stall_i carry envelope_value_o and skipped_o.
//   An item moves on a rising edge with valid high and stall low.
//   Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
//   index 0 centre time, 1 rise coefficient, 2 fall coefficient, 3 cutoff,
//   4 peak amplitude; other indexes are ignored. cfg_ready_o is always high.
//   Write configuration only while no item is in flight.
//   Throughput: one item per cycle unless out_stall_i holds a valid result;
//   the stages are the subtract, the absolute value and saturation, the
//   square, the two coefficient partial products, the scale sum, the log2(e)
//   multiply, the table read, the shift and the final amplitude multiply.
//   Reset clears the configuration registers and the valid bits, emptying the
//   pipeline.
//   While the receiver stalls a valid result, the whole pipeline holds and
//   in_stall_o is high; bubbles are carried, never collapsed.
module asymmetric_gaussian_envelope
  import agenv_pkg::*;
#(
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [31:0]          cfg_data_i,

  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [TimeW-1:0] time_tick_i,

  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [EnvW-1:0]      envelope_value_o,
  output logic                 skipped_o
);

  localparam int unsigned IdxW     = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned NStages  = 9;
  localparam real         InvDepth = 1.0 / real'(EXP_TABLE_DEPTH);

  function automatic env_t exp_entry(input int k);
    real v;
    v = 65535.0 * $pow(2.0, -real'(k) * InvDepth);
    return env_t'($rtoi(v + 0.5));
  endfunction

  env_t exp_tab [EXP_TABLE_DEPTH];

  for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_tab
    assign exp_tab[k] = exp_entry(k);
  end

  // configuration registers
  logic signed [TimeW-1:0] center_q;
  logic [CoefW-1:0]        rise_q, fall_q;
  env_t                    env_min_q, peak_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q  <= '0;
      rise_q    <= '0;
      fall_q    <= '0;
      env_min_q <= '0;
      peak_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegCenterTime: center_q  <= cfg_data_i;
        RegRiseCoeff:  rise_q    <= cfg_data_i;
        RegFallCoeff:  fall_q    <= cfg_data_i;
        RegEnvMin:     env_min_q <= cfg_data_i[EnvW-1:0];
        RegPeakAmp:    peak_q    <= cfg_data_i[EnvW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic               adv;
  logic [NStages-1:0] vld_q;

  assign out_valid_o = vld_q[NStages-1];
  assign adv         = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStages-2:0], in_valid_i};
    end
  end

  // datapath
  logic [TimeW:0]       s1_diff_d, s1_diff_q;
  logic [TimeW:0]       s2_mag;
  logic [DistW-1:0]     s2_d_d, s2_d_q;
  logic [CoefW-1:0]     s2_c_q, s3_c_q;
  logic [2*DistW-1:0]   s3_d2_q;
  logic [63:0]          s4_phi_q, s4_plo_q;
  logic [63:0]          s5_sum;
  logic [39:0]          s5_xw;
  logic [ExpW-1:0]      s5_x_d, s5_x_q;
  logic [ExpW+16:0]     s6_prod;
  logic [YW-1:0]        s6_y_q;
  logic [16+IdxW-1:0]   s7_idx_full;
  logic [IdxW-1:0]      s7_idx;
  env_t                 s7_tab_q;
  logic [ShiftW-1:0]    s7_sh_q;
  env_t                 s8_env_d, s8_env_q;
  logic                 s9_keep;
  logic [2*EnvW-1:0]    s9_prod;

  assign s1_diff_d = {time_tick_i[TimeW-1], time_tick_i} - {center_q[TimeW-1], center_q};

  assign s2_mag = s1_diff_q[TimeW] ? (~s1_diff_q + 1'b1) : s1_diff_q;
  assign s2_d_d = (|s2_mag[TimeW:DistW]) ? {DistW{1'b1}} : s2_mag[DistW-1:0];

  assign s5_sum = s4_phi_q + {16'd0, s4_plo_q[63:16]};
  assign s5_xw  = s5_sum[63:24];
  assign s5_x_d = (|s5_xw[39:ExpW]) ? {ExpW{1'b1}} : s5_xw[ExpW-1:0];

  assign s6_prod = {17'd0, s5_x_q} * {{ExpW{1'b0}}, Log2eQ16};

  assign s7_idx_full = {{IdxW{1'b0}}, s6_y_q[15:0]}
                       * (16+IdxW)'(EXP_TABLE_DEPTH);
  assign s7_idx      = s7_idx_full[16 +: IdxW];

  assign s8_env_d = (|s7_sh_q[ShiftW-1:4]) ? '0 : (s7_tab_q >> s7_sh_q[3:0]);

  assign s9_keep = s8_env_q > env_min_q;
  assign s9_prod = {16'd0, peak_q} * {16'd0, s8_env_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_diff_q        <= s1_diff_d;
      s2_d_q           <= s2_d_d;
      s2_c_q           <= s1_diff_q[TimeW] ? rise_q : fall_q;
      s3_d2_q          <= {{DistW{1'b0}}, s2_d_q} * {{DistW{1'b0}}, s2_d_q};
      s3_c_q           <= s2_c_q;
      s4_phi_q         <= {16'd0, s3_d2_q} * {48'd0, s3_c_q[31:16]};
      s4_plo_q         <= {16'd0, s3_d2_q} * {48'd0, s3_c_q[15:0]};
      s5_x_q           <= s5_x_d;
      s6_y_q           <= s6_prod[16 +: YW];
      s7_tab_q         <= exp_tab[s7_idx];
      s7_sh_q          <= s6_y_q[YW-1:16];
      s8_env_q         <= s8_env_d;
      envelope_value_o <= s9_keep ? s9_prod[2*EnvW-1:EnvW] : '0;
      skipped_o        <= !s9_keep;
    end
  end

`ifndef SYNTHESIS
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input not stalled while output is held");

  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && skipped_o) |-> (envelope_value_o == '0))
    else $error("skipped item carries a non-zero value");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted item lost at pipeline entry");

  a_zero_env: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NStages-2] && adv && (s8_env_q == '0)) |=> (out_valid_o && skipped_o))
    else $error("zero envelope not reported as skipped");
`endif

endmodule
